FILE: hdl/sei_pkg.sv
// Shared types, constants and table functions for the storm energy-intensity core.
package sei_pkg;

    localparam int SEI_STAGES = 16;
    localparam int LOG_W = 40;
    localparam int FRAC_SH = 32 - SEI_STAGES;

    localparam logic [25:0] K_0086 = 26'd36936719;
    localparam logic [31:0] K_2119 = 32'd2275258925;
    localparam logic [23:0] EI_MAX = 24'hFFFFFF;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    localparam logic [15:0] COEF_RESET [8] = '{
        16'd3848, 16'd37880, 16'd3323, 16'd49074,
        16'd4582, 16'd27093, 16'd5507, 16'd18422
    };

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_CLASS = 2'd1,
        ST_ZERO_DUR  = 2'd2,
        ST_SAT       = 2'd3
    } status_t;

    // Sideband that rides along with an item through the datapath.
    typedef struct packed {
        logic                    spec;
        status_t                 st;
        logic [15:0]             b;
        logic signed [LOG_W-1:0] ld;
        logic signed [LOG_W-1:0] lp;
        logic signed [LOG_W-1:0] la;
    } side_t;

    // Log chain word: index 0 is duration, 1 is rainfall, 2 is coefficient A.
    typedef struct packed {
        logic [2:0][30:0] y;
        logic [2:0][31:0] acc;
        logic [2:0][4:0]  ip;
        side_t            side;
    } log_t;

    typedef struct packed {
        logic [31:0] r;
        logic [31:0] f;
        logic [7:0]  k;
        side_t       side;
    } exp_t;

    function automatic logic [3:0] lead_one(input logic [15:0] x);
        logic [3:0] m;
        m = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (x[i]) begin
                m = 4'(i);
            end
        end
        return m;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        n = n_in;
        r = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Entry i holds 2^(2^-i) in unsigned Q2.30.
    function automatic logic [31:0] exp_tab(input int i);
        logic [63:0] t;
        t = 64'd1 << 31;
        for (int j = 1; j <= i; j++) begin
            t = isqrt64(t << 30);
        end
        return t[31:0];
    endfunction

endpackage

FILE: hdl/sei_if.sv
// Channel interfaces for storm records in and energy-intensity results out.
interface sei_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  storm_class;
    logic [15:0] rainfall;
    logic [15:0] duration;
    modport source (output valid, storm_class, rainfall, duration, input ready);
    modport sink (input valid, storm_class, rainfall, duration, output ready);
endinterface

interface sei_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] energy_intensity;
    logic [1:0]  status;
    modport source (output valid, energy_intensity, status, input ready);
    modport sink (input valid, energy_intensity, status, output ready);
endinterface

FILE: hdl/sei_log_cell.sv
// One log2 squaring cell: yields one fraction bit for each of three operands.
module sei_log_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  sei_pkg::log_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output sei_pkg::log_t  out_data
);

    logic          valid_reg;
    sei_pkg::log_t data_reg;
    sei_pkg::log_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        logic [61:0] sq;
        logic [31:0] q;
        data_next = in_data;
        for (int k = 0; k < 3; k++) begin
            sq = 62'(in_data.y[k]) * 62'(in_data.y[k]);
            q  = sq[61:30];
            data_next.acc[k] = {in_data.acc[k][30:0], q[31]};
            data_next.y[k]   = q[31] ? q[31:1] : q[30:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: hdl/sei_exp_cell.sv
// One exp2 cell: multiplies by its table root when the leading fraction bit is set.
module sei_exp_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [31:0]    tab,
    input  logic           in_valid,
    output logic           in_ready,
    input  sei_pkg::exp_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output sei_pkg::exp_t  out_data
);

    logic          valid_reg;
    sei_pkg::exp_t data_reg;
    sei_pkg::exp_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        logic [63:0] prod;
        prod = 64'(in_data.r) * 64'(tab);
        data_next   = in_data;
        data_next.f = {in_data.f[30:0], 1'b0};
        if (in_data.f[31]) begin
            data_next.r = prod[61:30];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: hdl/storm_energy_intensity_core.sv
// Storm energy-intensity core: EI = A * P^(2.119 * D^0.0086) / D^B in the log2 domain.
// Throughput: one record per cycle unless result.ready stalls the chain; every stage
// is a register with its own valid bit, so the chain of log and exp cells sets the
// depth, not the rate.
// Reset: rst_n clears all valid bits and loads the coefficient registers with their
// default values for storm classes I, IA, II and III.
module storm_energy_intensity_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    sei_in_if.sink      item,
    sei_out_if.source   result
);

    localparam int N = sei_pkg::SEI_STAGES;
    localparam int LW = sei_pkg::LOG_W;

    // Coefficient registers, even index A and odd index B per storm class.
    logic [15:0] coef_reg [8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < 8; i++) begin
                coef_reg[i] <= sei_pkg::COEF_RESET[i];
            end
        end else if (cfg_we) begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    // Entry stage: class lookup, special cases and normalization of the three
    // log operands into Q1.30 mantissas with their integer exponents.
    logic          log_v   [N+1];
    logic          log_rdy [N+1];
    sei_pkg::log_t log_d   [N+1];

    logic          ent_v_reg;
    sei_pkg::log_t ent_reg;
    sei_pkg::log_t ent_next;
    logic          ent_rdy;

    assign ent_rdy    = !ent_v_reg || log_rdy[0];
    assign item.ready = ent_rdy;
    assign log_v[0]   = ent_v_reg;
    assign log_d[0]   = ent_reg;

    always_comb
    begin
        logic [15:0] a_val;
        logic [15:0] x [3];
        logic [3:0]  m;
        a_val = coef_reg[{item.storm_class[1:0], 1'b0}];
        x[0]  = item.duration;
        x[1]  = item.rainfall;
        x[2]  = a_val;
        ent_next        = '0;
        ent_next.side.b = coef_reg[{item.storm_class[1:0], 1'b1}];
        for (int k = 0; k < 3; k++) begin
            m = sei_pkg::lead_one(x[k]);
            ent_next.y[k]  = 31'(x[k]) << (5'd30 - 5'(m));
            ent_next.ip[k] = 5'(m) - 5'd8;
        end
        if (item.storm_class[2]) begin
            ent_next.side.spec = 1'b1;
            ent_next.side.st   = sei_pkg::ST_BAD_CLASS;
        end else if (item.duration == '0) begin
            ent_next.side.spec = 1'b1;
            ent_next.side.st   = sei_pkg::ST_ZERO_DUR;
        end else if (item.rainfall == '0 || a_val == '0) begin
            ent_next.side.spec = 1'b1;
            ent_next.side.st   = sei_pkg::ST_OK;
        end else begin
            ent_next.side.spec = 1'b0;
            ent_next.side.st   = sei_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ent_v_reg <= 1'b0;
        end else if (ent_rdy) begin
            ent_v_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ent_rdy) begin
            ent_reg <= ent_next;
        end
    end

    // Log chain: each cell squares the mantissas and emits one fraction bit.
    for (genvar g = 0; g < N; g++) begin : g_log
        sei_log_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (log_v[g]),
            .in_ready  (log_rdy[g]),
            .in_data   (log_d[g]),
            .out_valid (log_v[g+1]),
            .out_ready (log_rdy[g+1]),
            .out_data  (log_d[g+1])
        );
    end

    // Stage M1: assemble the three logs and form t = 0.0086 * log2 D.
    logic          x1_v   [N+1];
    logic          x1_rdy [N+1];
    sei_pkg::exp_t x1_d   [N+1];

    logic          m1_v_reg;
    sei_pkg::exp_t m1_reg;
    sei_pkg::exp_t m1_next;

    assign log_rdy[N] = !m1_v_reg || x1_rdy[0];
    assign x1_v[0]    = m1_v_reg;
    assign x1_d[0]    = m1_reg;

    always_comb
    begin
        logic signed [LW-1:0] lg [3];
        logic [LW-1:0]        mag;
        logic [65:0]          prod;
        logic [LW-1:0]        t_mag;
        logic [LW-1:0]        t;
        for (int k = 0; k < 3; k++) begin
            lg[k] = {{3{log_d[N].ip[k][4]}}, log_d[N].ip[k],
                     log_d[N].acc[k] << sei_pkg::FRAC_SH};
        end
        mag   = lg[0][LW-1] ? LW'(-lg[0]) : LW'(lg[0]);
        prod  = 66'(mag) * 66'(sei_pkg::K_0086);
        t_mag = LW'(prod[65:32]);
        t     = lg[0][LW-1] ? -t_mag : t_mag;
        m1_next         = '0;
        m1_next.side    = log_d[N].side;
        m1_next.side.ld = lg[0];
        m1_next.side.lp = lg[1];
        m1_next.side.la = lg[2];
        m1_next.r       = sei_pkg::ONE_Q30;
        m1_next.f       = t[31:0];
        m1_next.k       = t[39:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m1_v_reg <= 1'b0;
        end else if (log_rdy[N]) begin
            m1_v_reg <= log_v[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (log_rdy[N]) begin
            m1_reg <= m1_next;
        end
    end

    // First exp chain: 2^t, for the rainfall exponent.
    for (genvar g = 0; g < N; g++) begin : g_exp1
        localparam logic [31:0] TAB = sei_pkg::exp_tab(g + 1);
        sei_exp_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .tab       (TAB),
            .in_valid  (x1_v[g]),
            .in_ready  (x1_rdy[g]),
            .in_data   (x1_d[g]),
            .out_valid (x1_v[g+1]),
            .out_ready (x1_rdy[g+1]),
            .out_data  (x1_d[g+1])
        );
    end

    // Stage M2: exponent e1 = 2.119 * 2^t, and B * log2 D in parallel.
    logic                 m2_v_reg;
    logic [35:0]          m2_e1_reg;
    logic signed [LW-1:0] m2_bl_reg;
    sei_pkg::side_t       m2_side_reg;
    logic [35:0]          m2_e1_next;
    logic signed [LW-1:0] m2_bl_next;
    logic                 m2_rdy;

    always_comb
    begin
        logic [63:0]   prod;
        logic [LW-1:0] mag;
        logic [55:0]   pb;
        logic [LW-1:0] blm;
        prod       = 64'(sei_pkg::K_2119) * 64'(x1_d[N].r);
        m2_e1_next = x1_d[N].k[7] ? 36'(prod[63:29]) : prod[63:28];
        mag = x1_d[N].side.ld[LW-1] ? LW'(-x1_d[N].side.ld) : LW'(x1_d[N].side.ld);
        pb  = 56'(mag) * 56'(x1_d[N].side.b);
        blm = LW'(pb[55:16]);
        m2_bl_next = x1_d[N].side.ld[LW-1] ? -blm : blm;
    end

    assign x1_rdy[N] = !m2_v_reg || m2_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m2_v_reg <= 1'b0;
        end else if (x1_rdy[N]) begin
            m2_v_reg <= x1_v[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (x1_rdy[N]) begin
            m2_e1_reg   <= m2_e1_next;
            m2_bl_reg   <= m2_bl_next;
            m2_side_reg <= x1_d[N].side;
        end
    end

    // Stage M3: e1 * |log2 P| as two partial products.
    logic                 m3_v_reg;
    logic [54:0]          m3_p0_reg;
    logic [56:0]          m3_p1_reg;
    logic                 m3_neg_reg;
    logic signed [LW-1:0] m3_bl_reg;
    sei_pkg::side_t       m3_side_reg;
    logic [LW-1:0]        m3_mag;
    logic                 m3_rdy;

    assign m3_mag = m2_side_reg.lp[LW-1] ? LW'(-m2_side_reg.lp) : LW'(m2_side_reg.lp);
    assign m2_rdy = !m3_v_reg || m3_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m3_v_reg <= 1'b0;
        end else if (m2_rdy) begin
            m3_v_reg <= m2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m2_rdy) begin
            m3_p0_reg   <= 55'(m2_e1_reg) * 55'(m3_mag[18:0]);
            m3_p1_reg   <= 57'(m2_e1_reg) * 57'(m3_mag[LW-1:19]);
            m3_neg_reg  <= m2_side_reg.lp[LW-1];
            m3_bl_reg   <= m2_bl_reg;
            m3_side_reg <= m2_side_reg;
        end
    end

    // Stage M4: combine partial products, truncate toward zero, restore sign.
    logic                 m4_v_reg;
    logic signed [LW-1:0] m4_m_reg;
    logic signed [LW-1:0] m4_bl_reg;
    sei_pkg::side_t       m4_side_reg;
    logic [75:0]          m4_sum;
    logic [LW-1:0]        m4_mm;
    logic                 m4_rdy;

    assign m4_sum = 76'(m3_p0_reg) + (76'(m3_p1_reg) << 19);
    assign m4_mm  = m4_sum[71:32];
    assign m3_rdy = !m4_v_reg || m4_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m4_v_reg <= 1'b0;
        end else if (m3_rdy) begin
            m4_v_reg <= m3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m3_rdy) begin
            m4_m_reg    <= m3_neg_reg ? -m4_mm : m4_mm;
            m4_bl_reg   <= m3_bl_reg;
            m4_side_reg <= m3_side_reg;
        end
    end

    // Stage M5: z = log2 A + e1 * log2 P - B * log2 D + 8, the signed Q8.32 log result.
    logic          x2_v   [N+1];
    logic          x2_rdy [N+1];
    sei_pkg::exp_t x2_d   [N+1];

    logic                 m5_v_reg;
    sei_pkg::exp_t        m5_reg;
    sei_pkg::exp_t        m5_next;
    logic signed [LW-1:0] z;

    assign z = m4_side_reg.la + m4_m_reg - m4_bl_reg + (LW'(8) << 32);
    assign m4_rdy  = !m5_v_reg || x2_rdy[0];
    assign x2_v[0] = m5_v_reg;
    assign x2_d[0] = m5_reg;

    always_comb
    begin
        m5_next      = '0;
        m5_next.side = m4_side_reg;
        m5_next.r    = sei_pkg::ONE_Q30;
        m5_next.f    = z[31:0];
        m5_next.k    = z[39:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m5_v_reg <= 1'b0;
        end else if (m4_rdy) begin
            m5_v_reg <= m4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m4_rdy) begin
            m5_reg <= m5_next;
        end
    end

    // Second exp chain: 2^frac(z).
    for (genvar g = 0; g < N; g++) begin : g_exp2
        localparam logic [31:0] TAB = sei_pkg::exp_tab(g + 1);
        sei_exp_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .tab       (TAB),
            .in_valid  (x2_v[g]),
            .in_ready  (x2_rdy[g]),
            .in_data   (x2_d[g]),
            .out_valid (x2_v[g+1]),
            .out_ready (x2_rdy[g+1]),
            .out_data  (x2_d[g+1])
        );
    end

    // Output register: scale by 2^k with round-half-up, saturate, and apply the
    // special cases decided at entry. It holds a finished transfer while the
    // stages behind it keep filling.
    logic            out_v_reg;
    logic [23:0]     out_ei_reg;
    sei_pkg::status_t out_st_reg;
    logic [23:0]     ei_next;
    sei_pkg::status_t st_next;

    always_comb
    begin
        logic signed [7:0] ks;
        logic [4:0]        sh;
        logic [32:0]       rnd;
        ks  = $signed(x2_d[N].k);
        sh  = 5'(8'd30 - x2_d[N].k);
        rnd = ({1'b0, x2_d[N].r} + (33'd1 << (sh - 5'd1))) >> sh;
        if (x2_d[N].side.spec) begin
            st_next = x2_d[N].side.st;
            ei_next = (x2_d[N].side.st == sei_pkg::ST_ZERO_DUR) ? sei_pkg::EI_MAX : '0;
        end else if (ks >= 8'sd24) begin
            st_next = sei_pkg::ST_SAT;
            ei_next = sei_pkg::EI_MAX;
        end else if (ks <= -8'sd2) begin
            st_next = sei_pkg::ST_OK;
            ei_next = '0;
        end else if (rnd > 33'(sei_pkg::EI_MAX)) begin
            st_next = sei_pkg::ST_SAT;
            ei_next = sei_pkg::EI_MAX;
        end else begin
            st_next = sei_pkg::ST_OK;
            ei_next = rnd[23:0];
        end
    end

    assign x2_rdy[N]               = !out_v_reg || result.ready;
    assign result.valid            = out_v_reg;
    assign result.energy_intensity = out_ei_reg;
    assign result.status           = out_st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_v_reg <= 1'b0;
        end else if (x2_rdy[N]) begin
            out_v_reg <= x2_v[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (x2_rdy[N]) begin
            out_ei_reg <= ei_next;
            out_st_reg <= st_next;
        end
    end

    // An invalid storm class always reports zero energy intensity.
    a_bad_class_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status == sei_pkg::ST_BAD_CLASS
        |-> result.energy_intensity == '0)
        else $error("invalid class result is not zero");

    // Zero duration and saturation both report the full-scale value.
    a_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.status == sei_pkg::ST_ZERO_DUR ||
                         result.status == sei_pkg::ST_SAT)
        |-> result.energy_intensity == sei_pkg::EI_MAX)
        else $error("saturated result is not full scale");

    // Every input transfer lands in the entry stage on the next cycle.
    a_entry_load: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> ent_v_reg)
        else $error("accepted record lost at entry");

endmodule
